@@ hdl/mi_pkg.sv @@
// Shared types for the modular inverse block: sequencer states and divider status.
`default_nettype none

package mi_pkg;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_REDUCE = 5'b00010,
        ST_CHECK  = 5'b00100,
        ST_ITER   = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

@@ hdl/mi_divider.sv @@
// Shared radix-2 restoring divider that also forms quotient times a coefficient.
`default_nettype none

module mi_divider
    import mi_pkg::*;
#(
    parameter int WORD_BITS = 64
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [WORD_BITS-1:0] dividend,
    input  wire logic [WORD_BITS-1:0] divisor,
    input  wire logic [WORD_BITS-1:0] coef,
    output logic [WORD_BITS-1:0]      remainder,
    output logic [WORD_BITS-1:0]      product,
    output div_status_t               status
);

    localparam int CNT_BITS = $clog2(WORD_BITS + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [WORD_BITS-1:0] rem_reg, rem_next;
    logic [WORD_BITS-1:0] dvd_reg, dvd_next;
    logic [WORD_BITS-1:0] dsr_reg, dsr_next;
    logic [WORD_BITS-1:0] coef_reg, coef_next;
    logic [WORD_BITS-1:0] prod_reg, prod_next;
    logic [WORD_BITS:0]   partial;
    logic [WORD_BITS:0]   diff;
    logic                 ge;

    // The product is built MSB first by Horner's rule as quotient bits appear.
    always_comb
    begin
        partial   = {rem_reg, dvd_reg[WORD_BITS-1]};
        diff      = partial - {1'b0, dsr_reg};
        ge        = (partial >= {1'b0, dsr_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        coef_next = coef_reg;
        prod_next = prod_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(WORD_BITS);
            rem_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            coef_next = coef;
            prod_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[WORD_BITS-1:0] : partial[WORD_BITS-1:0];
            dvd_next  = {dvd_reg[WORD_BITS-2:0], 1'b0};
            prod_next = {prod_reg[WORD_BITS-2:0], 1'b0} + (ge ? coef_reg : '0);
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        dsr_reg  <= dsr_next;
        coef_reg <= coef_next;
        prod_reg <= prod_next;
    end

    assign remainder   = rem_reg;
    assign product     = prod_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire

@@ hdl/modular_inverse.sv @@
// Top level of the modular inverse block: Euclid sequencer, coefficient registers, output word.
`default_nettype none

// Computes the inverse of value modulo modulus by the extended Euclidean algorithm.
// One word is processed at a time; each Euclid step runs one division on the shared
// one-bit-per-cycle divider, then the sequencer tests the new remainder in ST_CHECK.
// Before the first step the divider reduces value by modulus; a zero modulus skips the
// divider and goes straight to ST_FINISH. Input tready is high only while the sequencer
// is idle, and a finished result waits in an output register so that the next word may
// be taken while it is still pending.
module modular_inverse
    import mi_pkg::*;
#(
    parameter int WORD_BITS = 64
)
(
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      s_axis_tvalid,
    output logic                                           s_axis_tready,
    // Fields from bit 0: value (WORD_BITS bits), modulus (WORD_BITS-1 bits), zero fill.
    input  wire logic [((2*WORD_BITS-1+7)/8)*8-1:0]        s_axis_tdata,
    output logic                                           m_axis_tvalid,
    input  wire logic                                      m_axis_tready,
    // Fields from bit 0: inverse (WORD_BITS-1 bits), zero fill.
    output logic [((WORD_BITS-1+7)/8)*8-1:0]               m_axis_tdata,
    // Fields from bit 0: no_inverse.
    output logic                                           m_axis_tuser
);

    localparam int OUT_W = ((WORD_BITS - 1 + 7) / 8) * 8;

    state_t               state_reg, state_next;
    logic [WORD_BITS-1:0] r_reg, r_next;
    logic [WORD_BITS-1:0] newr_reg, newr_next;
    logic [WORD_BITS-1:0] t_reg, t_next;
    logic [WORD_BITS-1:0] newt_reg, newt_next;
    logic [WORD_BITS-1:0] mod_reg, mod_next;
    logic [WORD_BITS-2:0] inv_reg, inv_next;
    logic                 none_reg, none_next;
    logic                 out_valid_reg, out_valid_next;

    logic [WORD_BITS-1:0] in_value;
    logic [WORD_BITS-1:0] in_mod;
    logic                 div_start;
    logic [WORD_BITS-1:0] div_dividend;
    logic [WORD_BITS-1:0] div_divisor;
    logic [WORD_BITS-1:0] div_coef;
    logic [WORD_BITS-1:0] div_rem;
    logic [WORD_BITS-1:0] div_prod;
    div_status_t          div_status;

    logic                 calc_none;
    logic [WORD_BITS-1:0] calc_fixed;
    logic [WORD_BITS-2:0] calc_inv;
    logic                 load_out;
    logic [OUT_W-1:0]     out_data;

    assign in_value = s_axis_tdata[WORD_BITS-1:0];
    assign in_mod   = {1'b0, s_axis_tdata[2*WORD_BITS-2:WORD_BITS]};

    mi_divider #(
        .WORD_BITS (WORD_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .coef      (div_coef),
        .remainder (div_rem),
        .product   (div_prod),
        .status    (div_status)
    );

    always_comb
    begin
        calc_none  = (mod_reg == '0) || (r_reg > WORD_BITS'(1));
        calc_fixed = t_reg[WORD_BITS-1] ? (t_reg + mod_reg) : t_reg;
        calc_inv   = calc_none ? '0 : calc_fixed[WORD_BITS-2:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        r_next         = r_reg;
        newr_next      = newr_reg;
        t_next         = t_reg;
        newt_next      = newt_reg;
        mod_next       = mod_reg;
        inv_next       = inv_reg;
        none_next      = none_reg;
        div_start      = 1'b0;
        div_dividend   = r_reg;
        div_divisor    = newr_reg;
        div_coef       = newt_reg;
        load_out       = 1'b0;
        s_axis_tready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    mod_next = in_mod;
                    if (in_mod == '0)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        div_start    = 1'b1;
                        div_dividend = in_value;
                        div_divisor  = in_mod;
                        div_coef     = '0;
                        state_next   = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE:
            begin
                if (div_status.done)
                begin
                    r_next     = mod_reg;
                    newr_next  = div_rem;
                    t_next     = '0;
                    newt_next  = WORD_BITS'(1);
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (newr_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_ITER;
                end
            end
            ST_ITER:
            begin
                if (div_status.done)
                begin
                    t_next     = newt_reg;
                    newt_next  = t_reg - div_prod;
                    r_next     = newr_reg;
                    newr_next  = div_rem;
                    state_next = ST_CHECK;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    load_out   = 1'b1;
                    inv_next   = calc_inv;
                    none_next  = calc_none;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg    <= r_next;
        newr_reg <= newr_next;
        t_reg    <= t_next;
        newt_reg <= newt_next;
        mod_reg  <= mod_next;
        inv_reg  <= inv_next;
        none_reg <= none_next;
    end

    always_comb
    begin
        out_data                = '0;
        out_data[WORD_BITS-2:0] = inv_reg;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data;
    assign m_axis_tuser  = none_reg;

    // The divider is only started when it is free.
    a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_status.busy)
        else $error("divider started while busy");

    // A division result only arrives while the sequencer waits for one.
    a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> (state_reg == ST_REDUCE || state_reg == ST_ITER))
        else $error("unexpected divider completion");

    // An inverse that exists lies below the modulus.
    a_inv_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && !calc_none) |-> ({1'b0, calc_inv} < mod_reg))
        else $error("inverse out of range");

    // A result flagged as having no inverse carries zero.
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && none_reg) |-> (inv_reg == '0))
        else $error("nonzero inverse with no_inverse set");

    // An accepted word always leaves the idle state.
    a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg != ST_IDLE))
        else $error("accepted word not processed");

endmodule

`default_nettype wire

@@ tb/modular_inverse_tb.sv @@
// Testbench for modular_inverse: random and directed words checked against an extended Euclid predictor.
`default_nettype none

module modular_inverse_tb;

    localparam int WORD_BITS = 64;
    localparam int CYCLE_LIMIT = 8000000;
    localparam int LONG_HOLD = 20000;
    localparam int RANDOM_WORDS = 200;

    typedef struct {
        bit [63:0] value;
        bit [62:0] modulus;
        bit        drain;
    } inv_request_t;

    typedef struct {
        bit [62:0] inverse;
        bit        no_inverse;
    } inv_result_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [63:0]  m_axis_tdata;
    logic         m_axis_tuser;

    inv_request_t pending_words[$];
    inv_result_t  expected_inverses[$];
    inv_request_t cur_word;
    int           gap_left;
    int           burst_left;
    int           hold_left;
    bit           hold_done;
    int           ready_mode;
    int           mode_left;
    int           results_seen = 0;
    int           failures = 0;
    int           cycles = 0;

    modular_inverse #(
        .WORD_BITS(WORD_BITS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    function automatic inv_result_t predict_inverse(bit [63:0] value, bit [62:0] modulus);
        inv_result_t res;
        bit [63:0]   m;
        bit [63:0]   rem_a;
        bit [63:0]   rem_b;
        bit [63:0]   coef_a;
        bit [63:0]   coef_b;
        bit [63:0]   quot;
        bit [63:0]   tmp;
        res.inverse = '0;
        res.no_inverse = 1'b1;
        m = {1'b0, modulus};
        if (m != 0)
        begin
            rem_a = m;
            rem_b = value % m;
            coef_a = 0;
            coef_b = 1;
            while (rem_b != 0)
            begin
                quot = rem_a / rem_b;
                tmp = coef_a - quot * coef_b;
                coef_a = coef_b;
                coef_b = tmp;
                tmp = rem_a - quot * rem_b;
                rem_a = rem_b;
                rem_b = tmp;
            end
            if (rem_a <= 1)
            begin
                res.no_inverse = 1'b0;
                if (coef_a[63])
                    coef_a = coef_a + m;
                res.inverse = coef_a[62:0];
            end
        end
        return res;
    endfunction

    task automatic queue_word(bit [63:0] value, bit [62:0] modulus, bit drain);
        inv_request_t w;
        w.value = value;
        w.modulus = modulus;
        w.drain = drain;
        pending_words.push_back(w);
    endtask

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("modular_inverse_tb: FAIL");
            $finish;
        end
    end

    // Sender: bursts of words with random gaps; a word marked drain waits for all results.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            gap_left = 0;
            burst_left = 1;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_inverses.push_back(predict_inverse(cur_word.value, cur_word.modulus));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_words.size() == 0
                         || (pending_words[0].drain && expected_inverses.size() != 0))
                    s_axis_tvalid <= 1'b0;
                else
                begin
                    cur_word = pending_words.pop_front();
                    s_axis_tdata <= {1'b0, cur_word.modulus, cur_word.value};
                    s_axis_tvalid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 8);
                        if ($urandom_range(0, 3) == 0)
                            gap_left = $urandom_range(0, 3000);
                        else if ($urandom_range(0, 1) == 0)
                            gap_left = 0;
                        else
                            gap_left = $urandom_range(1, 20);
                    end
                    else
                        burst_left = burst_left - 1;
                end
            end
        end
    end

    // Receiver: changing stall patterns, plus one long hold-off to back the block up.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
            ready_mode <= 0;
            mode_left <= 0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!hold_done && results_seen >= 30)
        begin
            hold_done <= 1'b1;
            hold_left <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                ready_mode <= $urandom_range(0, 2);
                mode_left <= $urandom_range(10, 400);
            end
            else
                mode_left <= mode_left - 1;
            case (ready_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 1) == 1);
                default: m_axis_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        inv_result_t exp_res;
        int          errs;
        errs = 0;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen <= results_seen + 1;
            if (expected_inverses.size() == 0)
            begin
                $error("unexpected word: inverse %0d no_inverse %0b",
                       m_axis_tdata[62:0], m_axis_tuser);
                errs = errs + 1;
            end
            else
            begin
                exp_res = expected_inverses.pop_front();
                if (m_axis_tdata[62:0] !== exp_res.inverse)
                begin
                    $error("inverse: expected %0d actual %0d",
                           exp_res.inverse, m_axis_tdata[62:0]);
                    errs = errs + 1;
                end
                if (m_axis_tuser !== exp_res.no_inverse)
                begin
                    $error("no_inverse: expected %0b actual %0b",
                           exp_res.no_inverse, m_axis_tuser);
                    errs = errs + 1;
                end
            end
            if (errs != 0)
                failures <= failures + errs;
        end
    end

    initial
    begin
        bit [63:0] fib_lo;
        bit [63:0] fib_hi;
        bit [63:0] fib_tmp;
        bit [63:0] rnd_value;
        bit [62:0] rnd_mod;
        bit [63:0] factor;
        bit [63:0] wide;
        int        kind;
        int        steps;
        rst_n = 1'b0;

        fib_lo = 0;
        fib_hi = 1;
        for (int k = 0; k < 91; k++)
        begin
            fib_tmp = fib_lo + fib_hi;
            fib_lo = fib_hi;
            fib_hi = fib_tmp;
        end

        queue_word(64'd0, 63'd1, 1'b0);
        queue_word({64{1'b1}}, 63'd1, 1'b0);
        queue_word(64'd0, 63'd7, 1'b0);
        queue_word(64'd14, 63'd7, 1'b0);
        queue_word(64'd3, 63'd7, 1'b0);
        queue_word(64'd6, 63'd7, 1'b0);
        queue_word({64{1'b1}}, {63{1'b1}}, 1'b0);
        queue_word(64'd2, {63{1'b1}}, 1'b0);
        queue_word(64'd0, {63{1'b1}}, 1'b0);
        queue_word({1'b0, {63{1'b1}}}, {63{1'b1}}, 1'b0);
        queue_word(64'd1, 63'd2, 1'b0);
        queue_word(64'd4, 63'd6, 1'b0);
        queue_word(fib_lo, fib_hi[62:0], 1'b0);
        queue_word(fib_hi, fib_lo[62:0], 1'b0);
        queue_word(64'd5, 63'd0, 1'b1);
        queue_word({64{1'b1}}, 63'd0, 1'b0);
        queue_word(64'h8000_0000_0000_0000, 63'd1000000007, 1'b0);
        queue_word(64'd1000000006, 63'd1000000007, 1'b0);
        queue_word(64'hAAAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5555, 1'b0);
        queue_word(64'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA, 1'b0);

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            kind = $urandom_range(0, 9);
            rnd_value = {$urandom, $urandom};
            wide = {$urandom, $urandom} >> $urandom_range(1, 63);
            rnd_mod = wide[62:0];
            case (kind)
                5:
                begin
                    factor = 64'($urandom_range(2, 1000));
                    wide = factor * ({$urandom, $urandom} >> 14);
                    rnd_mod = wide[62:0];
                    rnd_value = factor * ({$urandom, $urandom} >> 10);
                end
                6: rnd_mod = 63'($urandom_range(1, 20));
                7:
                begin
                    steps = $urandom_range(2, 91);
                    fib_lo = 0;
                    fib_hi = 1;
                    for (int k = 0; k < steps; k++)
                    begin
                        fib_tmp = fib_lo + fib_hi;
                        fib_lo = fib_hi;
                        fib_hi = fib_tmp;
                    end
                    rnd_mod = fib_hi[62:0];
                    rnd_value = fib_lo + ($urandom_range(0, 1) ? fib_hi : 64'd0);
                end
                8:
                begin
                    if ($urandom_range(0, 1) == 0)
                        rnd_mod = {63{1'b1}};
                    else
                        rnd_value = {64{1'b1}};
                end
                9:
                begin
                    if (rnd_mod == 0)
                        rnd_mod = 63'd1;
                    rnd_value = {1'b0, rnd_mod} + ($urandom_range(0, 1) ? 64'd1 : -64'd1);
                end
                default: ;
            endcase
            if (rnd_mod == 0)
                rnd_mod = 63'd1;
            queue_word(rnd_value, rnd_mod, (i == 100) || (i == 160));
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        @(posedge clk);
        while (pending_words.size() != 0 || s_axis_tvalid || expected_inverses.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (failures == 0)
            $display("modular_inverse_tb: PASS");
        else
            $display("modular_inverse_tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
hdl/mi_pkg.sv
hdl/mi_divider.sv
hdl/modular_inverse.sv
tb/modular_inverse_tb.sv
